/* rtl/core/scd_pkg.sv */
package scd_pkg;

    localparam int SLOTS_DEF   = 64;
    localparam int MAX_RESULTS = 64;
    localparam int KIND_W      = 2;
    localparam int SECTOR_W    = 32;
    localparam int SLOT_W      = 6;

    typedef enum logic [KIND_W-1:0] {
        REQ_FETCH = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_FLUSH = 2'd3
    } req_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LK_SCAN,
        ST_LK_CMP,
        ST_HIT,
        ST_MISS,
        ST_SWEEP,
        ST_WB,
        ST_FILL,
        ST_FL_SCAN,
        ST_FL_GOT,
        ST_FL_END
    } state_t;

    typedef enum logic [2:0] {
        OUT_HIT,
        OUT_MISS,
        OUT_PEND_MID,
        OUT_PEND_LAST,
        OUT_EMPTY
    } out_sel_t;

    typedef struct packed {
        logic     in_ready;
        logic     idx_inc;
        logic     note_empty;
        logic     tag_rd;
        logic     rd_hand;
        logic     pick_empty;
        logic     pick_hand;
        logic     hand_adv;
        logic     wb_capture;
        logic     hit_update;
        logic     fill;
        logic     pend_load;
        logic     out_load;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic      in_valid;
        req_kind_t in_kind;
        logic      cur_valid;
        logic      cur_dirty;
        logic      idx_last;
        logic      tag_match;
        logic      empty_found;
        logic      hand_acc;
        logic      pend_valid;
        logic      pend_at_max;
        logic      out_free;
    } status_t;

endpackage

/* rtl/core/scd_if.sv */
interface scd_req_if;
    logic                          valid;
    logic                          ready;
    logic [scd_pkg::KIND_W-1:0]    req_type;
    logic [scd_pkg::SECTOR_W-1:0]  sector;

    modport source (output valid, req_type, sector, input ready);
    modport sink   (input valid, req_type, sector, output ready);
endinterface

interface scd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [scd_pkg::SLOT_W-1:0]    slot;
    logic                          hit;
    logic                          fill_needed;
    logic                          writeback;
    logic [scd_pkg::SECTOR_W-1:0]  writeback_sector;
    logic                          last;

    modport source (output valid, slot, hit, fill_needed, writeback, writeback_sector, last,
                    input ready);
    modport sink   (input valid, slot, hit, fill_needed, writeback, writeback_sector, last,
                    output ready);
endinterface

/* rtl/core/scd_ram.sv */
module scd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/scd_ctrl.sv */
module scd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  scd_pkg::status_t status,
    output scd_pkg::cmd_t    cmd
);

    scd_pkg::state_t state_reg;
    scd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.out_sel = scd_pkg::OUT_HIT;
        state_next = state_reg;
        case (state_reg)
            scd_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid)
                begin
                    if (status.in_kind == scd_pkg::REQ_FLUSH)
                    begin
                        state_next = scd_pkg::ST_FL_SCAN;
                    end
                    else
                    begin
                        state_next = scd_pkg::ST_LK_SCAN;
                    end
                end
            end
            // lookup: read tags of valid slots only, remember first empty one
            scd_pkg::ST_LK_SCAN:
            begin
                if (status.cur_valid)
                begin
                    cmd.tag_rd = 1'b1;
                    state_next = scd_pkg::ST_LK_CMP;
                end
                else
                begin
                    cmd.note_empty = 1'b1;
                    if (status.idx_last)
                    begin
                        state_next = scd_pkg::ST_MISS;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            scd_pkg::ST_LK_CMP:
            begin
                if (status.tag_match)
                begin
                    state_next = scd_pkg::ST_HIT;
                end
                else if (status.idx_last)
                begin
                    state_next = scd_pkg::ST_MISS;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next = scd_pkg::ST_LK_SCAN;
                end
            end
            scd_pkg::ST_HIT:
            begin
                if (status.out_free)
                begin
                    cmd.hit_update = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = scd_pkg::OUT_HIT;
                    state_next     = scd_pkg::ST_IDLE;
                end
            end
            scd_pkg::ST_MISS:
            begin
                if (status.empty_found)
                begin
                    cmd.pick_empty = 1'b1;
                    state_next     = scd_pkg::ST_FILL;
                end
                else
                begin
                    state_next = scd_pkg::ST_SWEEP;
                end
            end
            // clock sweep, one slot per cycle
            scd_pkg::ST_SWEEP:
            begin
                if (status.hand_acc)
                begin
                    cmd.hand_adv = 1'b1;
                end
                else
                begin
                    cmd.pick_hand = 1'b1;
                    cmd.tag_rd    = 1'b1;
                    cmd.rd_hand   = 1'b1;
                    state_next    = scd_pkg::ST_WB;
                end
            end
            scd_pkg::ST_WB:
            begin
                cmd.wb_capture = 1'b1;
                state_next     = scd_pkg::ST_FILL;
            end
            scd_pkg::ST_FILL:
            begin
                if (status.out_free)
                begin
                    cmd.fill     = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = scd_pkg::OUT_MISS;
                    state_next   = scd_pkg::ST_IDLE;
                end
            end
            // flush: one pending word held back so the final one carries last
            scd_pkg::ST_FL_SCAN:
            begin
                if (status.cur_valid && status.cur_dirty)
                begin
                    cmd.tag_rd = 1'b1;
                    state_next = scd_pkg::ST_FL_GOT;
                end
                else if (status.idx_last)
                begin
                    state_next = scd_pkg::ST_FL_END;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            scd_pkg::ST_FL_GOT:
            begin
                if (!status.pend_valid || status.out_free)
                begin
                    cmd.pend_load = 1'b1;
                    if (status.pend_valid)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = scd_pkg::OUT_PEND_MID;
                    end
                    if (status.pend_at_max || status.idx_last)
                    begin
                        state_next = scd_pkg::ST_FL_END;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = scd_pkg::ST_FL_SCAN;
                    end
                end
            end
            scd_pkg::ST_FL_END:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = status.pend_valid ? scd_pkg::OUT_PEND_LAST
                                                     : scd_pkg::OUT_EMPTY;
                    state_next   = scd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/scd_dp.sv */
module scd_dp #(
    parameter int SLOTS = scd_pkg::SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    scd_req_if.sink          req,
    scd_rsp_if.source        rsp,
    input  scd_pkg::cmd_t    cmd,
    output scd_pkg::status_t status
);

    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(scd_pkg::MAX_RESULTS + 1);
    localparam int SLOT_W   = scd_pkg::SLOT_W;
    localparam int SECTOR_W = scd_pkg::SECTOR_W;

    scd_pkg::req_kind_t  kind_reg;
    logic [SECTOR_W-1:0] sector_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    hand_reg;
    logic [IDX_W-1:0]    pick_reg;
    logic [IDX_W-1:0]    empty_idx_reg;
    logic                empty_found_reg;
    logic [SLOTS-1:0]    valid_reg;
    logic [SLOTS-1:0]    dirty_reg;
    logic [SLOTS-1:0]    acc_reg;
    logic                wb_reg;
    logic [SECTOR_W-1:0] wb_tag_reg;
    logic                pend_valid_reg;
    logic [IDX_W-1:0]    pend_slot_reg;
    logic [SECTOR_W-1:0] pend_tag_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                out_valid_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic                out_hit_reg;
    logic                out_fill_reg;
    logic                out_wb_reg;
    logic [SECTOR_W-1:0] out_wbs_reg;
    logic                out_last_reg;

    logic                capture;
    logic                out_free;
    logic [SECTOR_W-1:0] tag_rdata;
    logic [IDX_W-1:0]    tag_raddr;

    assign capture   = cmd.in_ready && req.valid;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign tag_raddr = cmd.rd_hand ? hand_reg : idx_reg;

    // tag store, no reset; only valid slots are ever read
    scd_ram #(
        .WIDTH (SECTOR_W),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (cmd.fill),
        .waddr (pick_reg),
        .wdata (sector_reg),
        .re    (cmd.tag_rd),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    // control and per-slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            dirty_reg       <= '0;
            acc_reg         <= '0;
            hand_reg        <= '0;
            idx_reg         <= '0;
            empty_found_reg <= 1'b0;
            pend_valid_reg  <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (capture)
            begin
                idx_reg         <= '0;
                empty_found_reg <= 1'b0;
                pend_valid_reg  <= 1'b0;
                cnt_reg         <= '0;
            end
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.note_empty)
            begin
                empty_found_reg <= 1'b1;
            end
            if (cmd.hand_adv)
            begin
                acc_reg[hand_reg] <= 1'b0;
                if (hand_reg == IDX_W'(SLOTS - 1))
                begin
                    hand_reg <= '0;
                end
                else
                begin
                    hand_reg <= hand_reg + 1'b1;
                end
            end
            if (cmd.hit_update)
            begin
                if (kind_reg != scd_pkg::REQ_FETCH)
                begin
                    acc_reg[idx_reg] <= 1'b1;
                end
                if (kind_reg == scd_pkg::REQ_WRITE)
                begin
                    dirty_reg[idx_reg] <= 1'b1;
                end
            end
            if (cmd.fill)
            begin
                valid_reg[pick_reg] <= 1'b1;
                dirty_reg[pick_reg] <= (kind_reg == scd_pkg::REQ_WRITE);
                acc_reg[pick_reg]   <= (kind_reg != scd_pkg::REQ_FETCH);
            end
            if (cmd.pend_load)
            begin
                pend_valid_reg <= 1'b1;
                cnt_reg        <= cnt_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            kind_reg   <= scd_pkg::req_kind_t'(req.req_type);
            sector_reg <= req.sector;
        end
        if (cmd.note_empty && !empty_found_reg)
        begin
            empty_idx_reg <= idx_reg;
        end
        if (cmd.pick_empty)
        begin
            pick_reg   <= empty_idx_reg;
            wb_reg     <= 1'b0;
            wb_tag_reg <= '0;
        end
        if (cmd.pick_hand)
        begin
            pick_reg <= hand_reg;
        end
        if (cmd.wb_capture)
        begin
            wb_reg     <= dirty_reg[pick_reg];
            wb_tag_reg <= dirty_reg[pick_reg] ? tag_rdata : '0;
        end
        if (cmd.pend_load)
        begin
            pend_slot_reg <= idx_reg;
            pend_tag_reg  <= tag_rdata;
        end
        if (cmd.out_load)
        begin
            case (cmd.out_sel)
                scd_pkg::OUT_HIT:
                begin
                    out_slot_reg <= SLOT_W'(idx_reg);
                    out_hit_reg  <= 1'b1;
                    out_fill_reg <= 1'b0;
                    out_wb_reg   <= 1'b0;
                    out_wbs_reg  <= '0;
                    out_last_reg <= 1'b1;
                end
                scd_pkg::OUT_MISS:
                begin
                    out_slot_reg <= SLOT_W'(pick_reg);
                    out_hit_reg  <= 1'b0;
                    out_fill_reg <= (kind_reg != scd_pkg::REQ_WRITE);
                    out_wb_reg   <= wb_reg;
                    out_wbs_reg  <= wb_tag_reg;
                    out_last_reg <= 1'b1;
                end
                scd_pkg::OUT_PEND_MID,
                scd_pkg::OUT_PEND_LAST:
                begin
                    out_slot_reg <= SLOT_W'(pend_slot_reg);
                    out_hit_reg  <= 1'b0;
                    out_fill_reg <= 1'b0;
                    out_wb_reg   <= 1'b1;
                    out_wbs_reg  <= pend_tag_reg;
                    out_last_reg <= (cmd.out_sel == scd_pkg::OUT_PEND_LAST);
                end
                default:
                begin
                    out_slot_reg <= '0;
                    out_hit_reg  <= 1'b0;
                    out_fill_reg <= 1'b0;
                    out_wb_reg   <= 1'b0;
                    out_wbs_reg  <= '0;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign req.ready            = cmd.in_ready;
    assign rsp.valid            = out_valid_reg;
    assign rsp.slot             = out_slot_reg;
    assign rsp.hit              = out_hit_reg;
    assign rsp.fill_needed      = out_fill_reg;
    assign rsp.writeback        = out_wb_reg;
    assign rsp.writeback_sector = out_wbs_reg;
    assign rsp.last             = out_last_reg;

    always_comb
    begin
        status.in_valid    = req.valid;
        status.in_kind     = scd_pkg::req_kind_t'(req.req_type);
        status.cur_valid   = valid_reg[idx_reg];
        status.cur_dirty   = dirty_reg[idx_reg];
        status.idx_last    = (idx_reg == IDX_W'(SLOTS - 1));
        status.tag_match   = (tag_rdata == sector_reg);
        status.empty_found = empty_found_reg;
        status.hand_acc    = acc_reg[hand_reg];
        status.pend_valid  = pend_valid_reg;
        status.pend_at_max = (cnt_reg == CNT_W'(scd_pkg::MAX_RESULTS - 1));
        status.out_free    = out_free;
    end

endmodule

/* rtl/core/sector_cache_clock_directory.sv */
// a lookup visits slots in order; a valid slot takes a tag ram read and then a compare,
//   while an empty slot takes only the scan step
// a miss with no empty slot adds the clock sweep, which clears set accessed bits as the hand
//   passes, then reads the victim's tag for a writeback if it is dirty, before the fill
// flush: walks the slots, reads the tag of each dirty slot, then closes; output stalls hold it
// one request at a time, next taken once its word sits in the output register; reset empties all
module sector_cache_clock_directory #(
    parameter int SLOTS = scd_pkg::SLOTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    scd_req_if.sink   req,
    scd_rsp_if.source rsp
);

    // command and status between the sequencer and the directory datapath
    scd_pkg::cmd_t    cmd;
    scd_pkg::status_t status;

    // sequencer: lookup scan, victim sweep, fill and flush walk
    scd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // datapath: per-slot valid, dirty and accessed bits, clock hand, tag ram,
    // flush hold-back word and the output register
    scd_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .status (status)
    );

endmodule
